@@ design/sgtf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the scaled glyph text frame buffer: screen geometry, transaction
// structs, controller command/status structs, state encoding and the 5x7 font.
// No dependencies.
package sgtf_pkg;

	localparam int SCREEN_WIDTH  = 240;
	localparam int SCREEN_HEIGHT = 240;
	localparam int STORE_DEPTH   = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W        = $clog2(STORE_DEPTH);
	localparam int X_W           = $clog2(SCREEN_WIDTH);
	localparam int Y_W           = $clog2(SCREEN_HEIGHT);

	// Working width of a pixel coordinate: a 10-bit origin plus the glyph extent.
	localparam int COORD_W       = 12;

	localparam int GLYPH_COLS    = 5;
	localparam int GLYPH_ROWS    = 7;
	localparam int GLYPH_ADVANCE = 6;

	typedef enum logic [1:0] {
		KIND_CLEAR     = 2'd0,
		KIND_DRAW_AT   = 2'd1,
		KIND_DRAW_PEN  = 2'd2,
		KIND_READ      = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t        kind;
		logic [9:0]   x_pos;
		logic [9:0]   y_pos;
		logic [7:0]   char_code;
		logic [15:0]  color;
		logic [3:0]   scale;
	} cmd_t;

	typedef struct packed {
		logic [15:0]  pixel_word;
		logic         in_range;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DOT,
		ST_PAINT,
		ST_READ,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic dot_next;
		logic paint_step;
		logic rd_issue;
		logic rsp_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic dot_lit;
		logic dot_last;
		logic sq_last;
		logic rsp_free;
	} dp_status_t;

	typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

	// Column-major font; column 0 is the rightmost entry of each literal, bit 0
	// of a column is the top row. Codes without a glyph come back blank.
	function automatic glyph_t glyph_of(input logic [7:0] code);
		glyph_t g;
		case (code)
			8'd45:   g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
			8'd46:   g = {7'h00, 7'h00, 7'h60, 7'h60, 7'h00};
			8'd58:   g = {7'h00, 7'h00, 7'h36, 7'h36, 7'h00};
			8'd48:   g = {7'h3e, 7'h45, 7'h49, 7'h51, 7'h3e};
			8'd49:   g = {7'h00, 7'h40, 7'h7f, 7'h42, 7'h00};
			8'd50:   g = {7'h46, 7'h49, 7'h51, 7'h61, 7'h42};
			8'd51:   g = {7'h31, 7'h4b, 7'h45, 7'h41, 7'h21};
			8'd52:   g = {7'h10, 7'h7f, 7'h12, 7'h14, 7'h18};
			8'd53:   g = {7'h39, 7'h45, 7'h45, 7'h45, 7'h27};
			8'd54:   g = {7'h30, 7'h49, 7'h49, 7'h4a, 7'h3c};
			8'd55:   g = {7'h03, 7'h05, 7'h09, 7'h71, 7'h01};
			8'd56:   g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
			8'd57:   g = {7'h1e, 7'h29, 7'h49, 7'h49, 7'h06};
			8'd65:   g = {7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e};
			8'd67:   g = {7'h22, 7'h41, 7'h41, 7'h41, 7'h3e};
			8'd68:   g = {7'h1c, 7'h22, 7'h41, 7'h41, 7'h7f};
			8'd69:   g = {7'h41, 7'h49, 7'h49, 7'h49, 7'h7f};
			8'd73:   g = {7'h00, 7'h41, 7'h7f, 7'h41, 7'h00};
			8'd77:   g = {7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f};
			8'd79:   g = {7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e};
			8'd80:   g = {7'h06, 7'h09, 7'h09, 7'h09, 7'h7f};
			8'd82:   g = {7'h46, 7'h29, 7'h19, 7'h09, 7'h7f};
			8'd83:   g = {7'h32, 7'h49, 7'h49, 7'h49, 7'h26};
			8'd84:   g = {7'h01, 7'h01, 7'h7f, 7'h01, 7'h01};
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

@@ design/sgtf_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine for the scaled glyph text frame buffer.
// Depends on sgtf_pkg; drives the datapath only through ctrl_cmd_t.
module sgtf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  sgtf_pkg::kind_t     cmd_kind,
	output logic                cmd_stall,
	input  sgtf_pkg::dp_status_t status,
	output sgtf_pkg::ctrl_cmd_t ctl
);
	import sgtf_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd_kind)
						KIND_CLEAR:                  state_next = ST_CLEAR;
						KIND_DRAW_AT, KIND_DRAW_PEN: state_next = ST_DOT;
						default:                     state_next = ST_READ;
					endcase
				end
			end
			ST_CLEAR: begin
				if (status.clr_last) state_next = ST_IDLE;
			end
			ST_DOT: begin
				if (status.dot_lit) state_next = ST_PAINT;
				else if (status.dot_last) state_next = ST_IDLE;
			end
			ST_PAINT: begin
				if (status.sq_last) state_next = status.dot_last ? ST_IDLE : ST_DOT;
			end
			ST_READ: state_next = ST_RESP;
			ST_RESP: begin
				if (status.rsp_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		cmd_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:  ctl.load = cmd_valid;
			ST_CLEAR: ctl.clr_step = 1'b1;
			ST_DOT:   ctl.dot_next = !status.dot_lit && !status.dot_last;
			ST_PAINT: begin
				ctl.paint_step = 1'b1;
				ctl.dot_next   = status.sq_last && !status.dot_last;
			end
			ST_READ:  ctl.rd_issue = 1'b1;
			ST_RESP:  ctl.rsp_load = status.rsp_free;
			default:  ctl = '0;
		endcase
	end

endmodule

@@ design/sgtf_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the scaled glyph text frame buffer: pen, dot and pixel walkers,
// the frame store and the response register. Depends on sgtf_pkg.
module sgtf_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sgtf_pkg::cmd_t       cmd,
	input  sgtf_pkg::ctrl_cmd_t  ctl,
	output sgtf_pkg::dp_status_t status,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output sgtf_pkg::rsp_t       rsp
);
	import sgtf_pkg::*;

	logic [15:0]        mem [STORE_DEPTH];

	logic [9:0]         pen_x_q, pen_y_q;
	logic [ADDR_W-1:0]  clr_cnt_q;
	glyph_t             glyph_q;
	logic [3:0]         scale_q;
	logic [15:0]        word_q;
	logic [2:0]         col_q, row_q;
	logic [3:0]         dx_q, dy_q;
	logic [COORD_W-1:0] org_y_q, dot_x_q, dot_y_q, px_q, py_q;
	logic [15:0]        rd_data_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [9:0]         org_x10, org_y10;
	logic [COORD_W-1:0] org_x, org_y, scale_w;
	logic               on_screen;
	logic [ADDR_W-1:0]  pix_addr;
	logic               row_end, dx_end;
	logic               we;
	logic [ADDR_W-1:0]  waddr;
	logic [15:0]        wdata;

	always_comb begin
		if (cmd.kind == KIND_DRAW_PEN) begin
			org_x10 = pen_x_q;
			org_y10 = pen_y_q;
		end else begin
			org_x10 = cmd.x_pos;
			org_y10 = cmd.y_pos;
		end
	end
	assign org_x   = {{(COORD_W-10){org_x10[9]}}, org_x10};
	assign org_y   = {{(COORD_W-10){org_y10[9]}}, org_y10};
	assign scale_w = COORD_W'(scale_q);

	// Coordinates are two's complement; a clear sign bit allows an unsigned compare.
	assign on_screen = !px_q[COORD_W-1] && (px_q < COORD_W'(SCREEN_WIDTH)) &&
	                   !py_q[COORD_W-1] && (py_q < COORD_W'(SCREEN_HEIGHT));
	assign pix_addr  = ADDR_W'(ADDR_W'(py_q[Y_W-1:0]) * ADDR_W'(SCREEN_WIDTH)) +
	                   ADDR_W'(px_q[X_W-1:0]);

	assign row_end = (row_q == 3'(GLYPH_ROWS - 1));
	assign dx_end  = (dx_q == scale_q - 4'd1);

	assign status.clr_last = (clr_cnt_q == ADDR_W'(STORE_DEPTH - 1));
	assign status.dot_lit  = glyph_q[col_q][row_q] && (scale_q != 4'd0);
	assign status.dot_last = row_end && (col_q == 3'(GLYPH_COLS - 1));
	assign status.sq_last  = dx_end && (dy_q == scale_q - 4'd1);
	assign status.rsp_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
		end else if (ctl.load &&
		             (cmd.kind == KIND_DRAW_AT || cmd.kind == KIND_DRAW_PEN)) begin
			pen_x_q <= org_x10 + 10'(10'(GLYPH_ADVANCE) * 10'(cmd.scale));
			pen_y_q <= org_y10;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			clr_cnt_q <= '0;
			glyph_q   <= glyph_of(cmd.char_code);
			scale_q   <= cmd.scale;
			word_q    <= {cmd.color[7:0], cmd.color[15:8]};
			col_q     <= '0;
			row_q     <= '0;
			dx_q      <= '0;
			dy_q      <= '0;
			org_y_q   <= org_y;
			dot_x_q   <= org_x;
			dot_y_q   <= org_y;
			px_q      <= org_x;
			py_q      <= org_y;
		end else begin
			if (ctl.clr_step) clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			if (ctl.dot_next) begin
				dx_q <= '0;
				dy_q <= '0;
				if (row_end) begin
					row_q   <= '0;
					col_q   <= col_q + 3'd1;
					dot_x_q <= dot_x_q + scale_w;
					dot_y_q <= org_y_q;
					px_q    <= dot_x_q + scale_w;
					py_q    <= org_y_q;
				end else begin
					row_q   <= row_q + 3'd1;
					dot_y_q <= dot_y_q + scale_w;
					px_q    <= dot_x_q;
					py_q    <= dot_y_q + scale_w;
				end
			end else if (ctl.paint_step) begin
				if (dx_end) begin
					dx_q <= '0;
					dy_q <= dy_q + 4'd1;
					px_q <= dot_x_q;
					py_q <= py_q + COORD_W'(1);
				end else begin
					dx_q <= dx_q + 4'd1;
					px_q <= px_q + COORD_W'(1);
				end
			end
		end
	end

	// Frame store: one write port shared by clear and paint, one registered read.
	assign we    = ctl.clr_step || (ctl.paint_step && on_screen);
	assign waddr = ctl.clr_step ? clr_cnt_q : pix_addr;
	assign wdata = ctl.clr_step ? 16'h0000 : word_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (ctl.rd_issue) rd_data_q <= mem[pix_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// The read address was held in px_q/py_q since the command was taken.
	always_ff @(posedge clk) begin
		if (ctl.rsp_load) begin
			rsp_q.pixel_word <= on_screen ? rd_data_q : 16'h0000;
			rsp_q.in_range   <= on_screen;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ design/scaled_glyph_text_framebuffer.sv @@
`timescale 1ns / 1ps
// Top level of the scaled glyph text frame buffer: joins the controller and
// the datapath. Depends on sgtf_pkg, sgtf_ctrl and sgtf_datapath.
//
//   Channel   Handshake              Payload            Direction
//   command   cmd_valid / cmd_stall  cmd (cmd_t)        into the block
//   response  rsp_valid / rsp_stall  rsp (rsp_t)        out of the block
//
// Work per command transaction after acceptance:
//   clear: SCREEN_WIDTH * SCREEN_HEIGHT store words, one store word per cycle.
//   draw:  a step for each of the 35 dots plus scale*scale pixel steps for each
//          lit dot, paced by the single store write port.
//   read:  a registered store read, then the response register; it waits
//          while the response register is still held by rsp_stall.
// A command is taken only while the controller is idle; a pending response
// does not block the next command. Reset clears the pen and control state;
// the frame store holds no defined contents until a clear or a draw.
module scaled_glyph_text_framebuffer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  sgtf_pkg::cmd_t   cmd,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output sgtf_pkg::rsp_t   rsp
);
	import sgtf_pkg::*;

	ctrl_cmd_t  ctl;
	dp_status_t status;

	// The controller sequences clear sweeps, dot and pixel walks, and reads.
	sgtf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_kind  (cmd.kind),
		.cmd_stall (cmd_stall),
		.status    (status),
		.ctl       (ctl)
	);

	// The datapath holds the pen, the walkers, the frame store and the output.
	sgtf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
